// ===== rtl/core/lpsp_pkg.sv =====
// Package for the LED point sequence player: sizes, request and register codes,
// and the command and status structs between the controller and the datapath.
// Depends on nothing.
package lpsp_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int HOLD_BITS   = 24;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	localparam int ADDR_W = 6;
	localparam int COLOR_W = 8;
	localparam int HOLD_W = 25;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;
	localparam int REPEAT_W = 7;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;
	localparam logic [1:0] REQ_STOP  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 1'd1;

	typedef enum logic [1:0] {
		RD_CUR,
		RD_NEXT,
		RD_ZERO
	} rd_sel_t;

	typedef struct packed {
		logic [COLOR_W-1:0]       red;
		logic [COLOR_W-1:0]       green;
		logic [COLOR_W-1:0]       blue;
		logic signed [HOLD_W-1:0] hold;
	} entry_t;

	typedef struct packed {
		logic    write;
		logic    count_tick;
		logic    start;
		logic    stop;
		logic    advance;
		logic    wrap;
		logic    finish;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    show;
		logic    blank;
	} cmd_t;

	typedef struct packed {
		logic playing;
		logic hold_due;
		logic past_end;
		logic rd_end;
		logic last_repeat;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/lpsp_if.sv =====
// Handshake channels of the LED point sequence player: request, result and
// configuration write. Depends on lpsp_pkg.
interface lpsp_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             req_type;
	logic [lpsp_pkg::ADDR_W-1:0]            entry_addr;
	logic [lpsp_pkg::COLOR_W-1:0]           entry_red;
	logic [lpsp_pkg::COLOR_W-1:0]           entry_green;
	logic [lpsp_pkg::COLOR_W-1:0]           entry_blue;
	logic signed [lpsp_pkg::HOLD_W-1:0]     entry_hold_ms;

	modport source (output valid, req_type, entry_addr, entry_red, entry_green, entry_blue,
		entry_hold_ms, input ready);
	modport sink (input valid, req_type, entry_addr, entry_red, entry_green, entry_blue,
		entry_hold_ms, output ready);
endinterface

interface lpsp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lpsp_pkg::COLOR_W-1:0]  out_red;
	logic [lpsp_pkg::COLOR_W-1:0]  out_green;
	logic [lpsp_pkg::COLOR_W-1:0]  out_blue;
	logic [lpsp_pkg::ADDR_W-1:0]   shown_index;
	logic                          is_playing;

	modport source (output valid, out_red, out_green, out_blue, shown_index, is_playing,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, shown_index, is_playing,
		output ready);
endinterface

interface lpsp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lpsp_pkg::CFG_IDX_W-1:0]   index;
	logic [lpsp_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lpsp_ctrl.sv =====
// Controller of the LED point sequence player: the state machine that takes
// requests and sequences table reads and result transfers. Depends on lpsp_pkg.
module lpsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_type,
	output logic                req_ready,
	input  lpsp_pkg::status_t   status,
	output lpsp_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_NEXT,
		S_SHOW,
		S_BLANK
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd       = '0;
		cmd.rd_sel = lpsp_pkg::RD_CUR;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						lpsp_pkg::REQ_TICK: begin
							if (status.playing) begin
								cmd.count_tick = 1'b1;
								cmd.rd_en      = 1'b1;
								cmd.rd_sel     = lpsp_pkg::RD_CUR;
								state_nxt      = S_CHECK;
							end
						end
						lpsp_pkg::REQ_LOAD: cmd.write = 1'b1;
						lpsp_pkg::REQ_START: begin
							cmd.start  = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = lpsp_pkg::RD_ZERO;
							state_nxt  = S_SHOW;
						end
						default: begin
							cmd.stop  = 1'b1;
							state_nxt = S_BLANK;
						end
					endcase
				end
			end
			S_CHECK, S_NEXT: begin
				if (state_q == S_CHECK && !status.hold_due) begin
					state_nxt = S_IDLE;
				end else if ((state_q == S_CHECK && status.past_end) ||
						(state_q == S_NEXT && status.rd_end)) begin
					if (status.last_repeat) begin
						cmd.finish = 1'b1;
						state_nxt  = S_BLANK;
					end else begin
						cmd.wrap   = 1'b1;
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = lpsp_pkg::RD_ZERO;
						state_nxt  = S_SHOW;
					end
				end else if (state_q == S_CHECK) begin
					cmd.advance = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = lpsp_pkg::RD_NEXT;
					state_nxt   = S_NEXT;
				end else begin
					state_nxt = S_SHOW;
				end
			end
			S_SHOW: begin
				if (status.out_free) begin
					cmd.show  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_BLANK: begin
				if (status.out_free) begin
					cmd.blank = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/lpsp_dp.sv =====
// Datapath of the LED point sequence player: point table, play registers,
// configuration registers and the result register. Depends on lpsp_pkg and lpsp_if.
module lpsp_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	lpsp_req_if.sink             req,
	lpsp_rsp_if.source           rsp,
	lpsp_cfg_if.sink             cfg,
	input  lpsp_pkg::cmd_t       cmd,
	output lpsp_pkg::status_t    status
);

	lpsp_pkg::entry_t mem [lpsp_pkg::TABLE_DEPTH];
	lpsp_pkg::entry_t rdata_q;

	logic                              playing_q;
	logic [lpsp_pkg::IDX_W-1:0]        idx_q;
	logic [lpsp_pkg::IDX_W-1:0]        nidx;
	logic [lpsp_pkg::IDX_W-1:0]        rd_addr;
	logic [lpsp_pkg::HOLD_BITS-1:0]    elapsed_q;
	logic [lpsp_pkg::REPEAT_W-1:0]     repeats_q;
	logic                              play_mode_q;
	logic [lpsp_pkg::REPEAT_W-1:0]     repeat_count_q;
	logic                              out_valid_q;
	logic                              wr_in_range;

	assign nidx        = idx_q + 1'b1;
	assign wr_in_range = (32'(req.entry_addr) < 32'(lpsp_pkg::TABLE_DEPTH));

	always_comb begin
		case (cmd.rd_sel)
			lpsp_pkg::RD_CUR:  rd_addr = idx_q;
			lpsp_pkg::RD_NEXT: rd_addr = nidx;
			default:           rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.write && wr_in_range) begin
			mem[lpsp_pkg::IDX_W'(req.entry_addr)] <= '{red: req.entry_red,
				green: req.entry_green, blue: req.entry_blue, hold: req.entry_hold_ms};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign status.playing     = playing_q;
	assign status.hold_due    = !rdata_q.hold[lpsp_pkg::HOLD_W-1] &&
		(32'(rdata_q.hold[lpsp_pkg::HOLD_W-2:0]) <= 32'(elapsed_q));
	assign status.past_end    = (idx_q == lpsp_pkg::IDX_W'(lpsp_pkg::TABLE_DEPTH - 1));
	assign status.rd_end      = rdata_q.hold[lpsp_pkg::HOLD_W-1];
	assign status.last_repeat = play_mode_q && (repeats_q <= lpsp_pkg::REPEAT_W'(1));
	assign status.out_free    = !out_valid_q || rsp.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q    <= 1'b0;
			repeat_count_q <= lpsp_pkg::REPEAT_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				lpsp_pkg::CFG_PLAY_MODE:    play_mode_q <= cfg.data[0];
				lpsp_pkg::CFG_REPEAT_COUNT: repeat_count_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			idx_q     <= '0;
			elapsed_q <= '0;
			repeats_q <= lpsp_pkg::REPEAT_W'(1);
		end else begin
			if (cmd.count_tick && elapsed_q != '1) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
			if (cmd.start) begin
				playing_q <= 1'b1;
				idx_q     <= '0;
				elapsed_q <= '0;
				repeats_q <= repeat_count_q;
			end
			if (cmd.stop || cmd.finish) begin
				playing_q <= 1'b0;
				idx_q     <= '0;
				elapsed_q <= '0;
			end
			if (cmd.finish) begin
				repeats_q <= '0;
			end
			if (cmd.advance) begin
				idx_q     <= nidx;
				elapsed_q <= '0;
			end
			if (cmd.wrap) begin
				idx_q     <= '0;
				elapsed_q <= '0;
				if (play_mode_q) begin
					repeats_q <= repeats_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.show || cmd.blank) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.show) begin
			rsp.out_red     <= rdata_q.red;
			rsp.out_green   <= rdata_q.green;
			rsp.out_blue    <= rdata_q.blue;
			rsp.shown_index <= lpsp_pkg::ADDR_W'(idx_q);
			rsp.is_playing  <= 1'b1;
		end else if (cmd.blank) begin
			rsp.out_red     <= '0;
			rsp.out_green   <= '0;
			rsp.out_blue    <= '0;
			rsp.shown_index <= '0;
			rsp.is_playing  <= 1'b0;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

// ===== rtl/core/led_point_sequence_player_core.sv =====
// LED point sequence player, top level.
// Request channel req: tick (one millisecond), load table entry, start, stop.
// Result channel rsp: the colour shown on every pixel, the shown entry and
// whether a sequence runs. Configuration channel cfg: play mode (index 0) and
// repeat count (index 1), always ready; the user must write it only while the
// block is idle, which the block does not enforce. A load gives no result. A
// stop or start waits in the blank or show state for a free output register.
// A tick while playing reads the current point, goes back to idle if it is not
// due, else reads and shows the next point, wrapping to zero or blanking at the
// last repeat. Reads are registered. One request is in work at a time.
// A finished result waits in the output register; a new request is taken
// while it waits, and a second result waits until the first is transferred.
// Reset stops the player, clears the play registers and sets play mode to
// loop and repeat count to one; the point table keeps no reset value.
// Depends on lpsp_pkg, lpsp_if, lpsp_ctrl and lpsp_dp.
module led_point_sequence_player_core (
	input  logic        clk,
	input  logic        arst_n,
	lpsp_req_if.sink    req,
	lpsp_rsp_if.source  rsp,
	lpsp_cfg_if.sink    cfg
);

	lpsp_pkg::cmd_t    cmd;
	lpsp_pkg::status_t status;

	lpsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lpsp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule

// ===== dv/led_point_sequence_player_core_test.sv =====
// Self-checking bench for led_point_sequence_player_core: a scripted opening, then random
// table loads, starts, stops and millisecond ticks under changing play settings, with every
// picture compared against an in-bench player. Depends on lpsp_pkg, lpsp_if and the RTL.
module led_point_sequence_player_core_test;
	import lpsp_pkg::*;

	localparam int LIMIT = 400000;
	localparam int ITEMS = 2000;
	localparam int SETTLE = 8;
	localparam int SCRIPT_LEN = 23;
	localparam logic [HOLD_BITS-1:0] HOLD_CAP = '1;

	typedef struct packed {
		logic [1:0]               kind;
		logic [ADDR_W-1:0]        addr;
		logic [COLOR_W-1:0]       red;
		logic [COLOR_W-1:0]       green;
		logic [COLOR_W-1:0]       blue;
		logic signed [HOLD_W-1:0] hold;
	} request_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [ADDR_W-1:0]  index;
		logic               playing;
	} picture_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		logic     shows;
		picture_t pic;
	} script_row_t;

	localparam picture_t NO_PIC = '0;
	localparam picture_t WHITE_AT_0 = '{8'hFF, 8'hFF, 8'hFF, 6'd0, 1'b1};
	localparam picture_t MARKER_AT_0 = '{8'h80, 8'h01, 8'h7F, 6'd0, 1'b1};

	script_row_t script [SCRIPT_LEN] = '{
		'{'{REQ_STOP,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b1, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b0, NO_PIC},
		'{'{REQ_LOAD,  6'd0,  8'hFF, 8'hFF, 8'hFF, 25'sd0},        1'b1, 1'b0, NO_PIC},
		'{'{REQ_LOAD,  6'd1,  8'h00, 8'h00, 8'h00, 25'sd1},        1'b1, 1'b0, NO_PIC},
		'{'{REQ_LOAD,  6'd2,  8'h5A, 8'hA5, 8'h3C, 25'sd2},        1'b1, 1'b0, NO_PIC},
		'{'{REQ_LOAD,  6'd3,  8'h12, 8'h34, 8'h56, -25'sd1},       1'b1, 1'b0, NO_PIC},
		'{'{REQ_LOAD,  6'd63, 8'h00, 8'h00, 8'h00, 25'sd16777215}, 1'b1, 1'b0, NO_PIC},
		'{'{REQ_START, 6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b1, WHITE_AT_0},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_START, 6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b1, WHITE_AT_0},
		'{'{REQ_LOAD,  6'd2,  8'h00, 8'hFF, 8'h00, 25'sd16777215}, 1'b1, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_STOP,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b1, NO_PIC},
		'{'{REQ_LOAD,  6'd0,  8'h80, 8'h01, 8'h7F, 25'h1000000},   1'b1, 1'b0, NO_PIC},
		'{'{REQ_START, 6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b1, MARKER_AT_0},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b0, 1'b0, NO_PIC},
		'{'{REQ_STOP,  6'd0,  8'h00, 8'h00, 8'h00, 25'sd0},        1'b1, 1'b1, NO_PIC}
	};

	logic clk;
	logic arst_n;
	logic calm = 1'b0;

	lpsp_req_if req_ch();
	lpsp_rsp_if rsp_ch();
	lpsp_cfg_if cfg_ch();

	led_point_sequence_player_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	entry_t               points [TABLE_DEPTH];
	logic                 player_on;
	logic [IDX_W:0]       at_point;
	logic [HOLD_BITS-1:0] held_ms;
	logic [REPEAT_W-1:0]  plays_left;
	logic                 counted_mode;
	logic [REPEAT_W-1:0]  plays_set;

	picture_t pictures_due [$];
	int mismatches = 0;
	int checked = 0;
	int cycles = 0;
	int n_ticks = 0;
	int n_loads = 0;
	int n_starts = 0;
	int n_stops = 0;
	int n_settings = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("led_point_sequence_player_core_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 14);

	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		$display("mismatch at cycle %0d: %s expected %0d, got %0d", cycles, what, want, got);
	endtask

	always @(posedge clk) begin
		picture_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pictures_due.size() == 0) begin
				flag_mismatch("picture count with none pending", 0, 1);
			end else begin
				want = pictures_due.pop_front();
				checked++;
				if (rsp_ch.out_red !== want.red)
					flag_mismatch("out_red", want.red, rsp_ch.out_red);
				if (rsp_ch.out_green !== want.green)
					flag_mismatch("out_green", want.green, rsp_ch.out_green);
				if (rsp_ch.out_blue !== want.blue)
					flag_mismatch("out_blue", want.blue, rsp_ch.out_blue);
				if (rsp_ch.shown_index !== want.index)
					flag_mismatch("shown_index", want.index, rsp_ch.shown_index);
				if (rsp_ch.is_playing !== want.playing)
					flag_mismatch("is_playing", want.playing, rsp_ch.is_playing);
			end
		end
	end

	function automatic picture_t picture(input logic blank);
		picture_t p;
		p = '0;
		if (!blank && at_point < TABLE_DEPTH) begin
			p.red = points[at_point].red;
			p.green = points[at_point].green;
			p.blue = points[at_point].blue;
			p.index = at_point[IDX_W-1:0];
		end
		p.playing = !blank;
		return p;
	endfunction

	function automatic void halt_player();
		player_on = 1'b0;
		at_point = '0;
		held_ms = '0;
	endfunction

	// Steps the bench's own copy of the player by one accepted request.
	function automatic logic play_request(input request_t r, output picture_t p);
		int   hold;
		logic wrap;
		p = '0;
		case (r.kind)
			REQ_LOAD: begin
				points[r.addr] = {r.red, r.green, r.blue, r.hold};
				return 1'b0;
			end
			REQ_START: begin
				player_on = 1'b1;
				at_point = '0;
				held_ms = '0;
				plays_left = plays_set;
				p = picture(1'b0);
				return 1'b1;
			end
			REQ_STOP: begin
				halt_player();
				p = picture(1'b1);
				return 1'b1;
			end
			default: ;
		endcase
		if (!player_on)
			return 1'b0;
		if (held_ms != HOLD_CAP)
			held_ms++;
		hold = (at_point < TABLE_DEPTH) ? $signed(points[at_point].hold) : -1;
		if (hold < 0 || hold > int'(held_ms))
			return 1'b0;
		held_ms = '0;
		at_point++;
		if (at_point >= TABLE_DEPTH)
			wrap = 1'b1;
		else
			wrap = $signed(points[at_point].hold) < 0;
		if (wrap) begin
			at_point = '0;
			if (counted_mode) begin
				if (plays_left <= 1) begin
					plays_left = '0;
					halt_player();
					p = picture(1'b1);
					return 1'b1;
				end
				plays_left--;
			end
		end
		p = picture(1'b0);
		return 1'b1;
	endfunction

	task automatic send(input request_t r);
		if (!calm) begin
			while ($urandom_range(0, 99) < 14) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.entry_addr <= r.addr;
		req_ch.entry_red <= r.red;
		req_ch.entry_green <= r.green;
		req_ch.entry_blue <= r.blue;
		req_ch.entry_hold_ms <= r.hold;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic issue(input request_t r, input logic typed, input logic shows,
		input picture_t pic);
		picture_t next_pic;
		logic     makes;
		send(r);
		makes = play_request(r, next_pic);
		if (typed) begin
			if (shows)
				pictures_due.push_back(pic);
		end else if (makes) begin
			pictures_due.push_back(next_pic);
		end
		case (r.kind)
			REQ_TICK:  n_ticks++;
			REQ_LOAD:  n_loads++;
			REQ_START: n_starts++;
			default:   n_stops++;
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_PLAY_MODE)
			counted_mode = value[0];
		else
			plays_set = value[REPEAT_W-1:0];
	endtask

	task automatic apply_setting(input logic mode, input logic [REPEAT_W-1:0] count);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(CFG_PLAY_MODE, CFG_DATA_W'(mode));
			write_reg(CFG_REPEAT_COUNT, count);
		end else begin
			write_reg(CFG_REPEAT_COUNT, count);
			write_reg(CFG_PLAY_MODE, CFG_DATA_W'(mode));
		end
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	// The block may still be busy on a quiet tick after the last picture.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pictures_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic request_t noise();
		request_t r;
		r.kind = 2'($urandom);
		r.addr = 6'($urandom);
		r.red = 8'($urandom);
		r.green = 8'($urandom);
		r.blue = 8'($urandom);
		r.hold = 25'($urandom);
		return r;
	endfunction

	function automatic logic signed [HOLD_W-1:0] step_hold();
		if ($urandom_range(0, 9) == 0)
			return HOLD_W'($urandom_range(3, 12));
		return HOLD_W'($urandom_range(0, 2));
	endfunction

	function automatic logic signed [HOLD_W-1:0] any_hold();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return HOLD_W'($urandom_range(0, 3));
		if (pick < 75)
			return HOLD_W'($urandom_range(4, 20));
		if (pick < 88)
			return {1'b1, 24'($urandom)};
		return 25'($urandom);
	endfunction

	initial begin
		request_t r;
		int       phase;
		int       n_random;
		int       pick;
		int       len;
		int       burst;
		logic     steady;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_TICK;
		req_ch.entry_addr <= '0;
		req_ch.entry_red <= '0;
		req_ch.entry_green <= '0;
		req_ch.entry_blue <= '0;
		req_ch.entry_hold_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_PLAY_MODE;
		cfg_ch.data <= '0;
		player_on = 1'b0;
		at_point = '0;
		held_ms = '0;
		plays_left = REPEAT_W'(1);
		counted_mode = 1'b0;
		plays_set = REPEAT_W'(1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			issue(script[i].req, script[i].typed, script[i].shows, script[i].pic);

		n_random = 0;
		phase = 0;
		while (n_random < ITEMS) begin
			settle();
			calm = (phase == 3);
			case (phase)
				0: apply_setting(1'b0, 7'd0);
				1: apply_setting(1'b1, 7'd0);
				2: apply_setting(1'b1, 7'd1);
				3: apply_setting(1'b1, 7'd127);
				4: apply_setting(1'b0, 7'd127);
				default: apply_setting(1'($urandom), ($urandom_range(0, 3) == 0) ?
					7'($urandom) : 7'($urandom_range(1, 4)));
			endcase
			pick = $urandom_range(0, 99);
			if (phase == 0 || pick >= 90)
				len = TABLE_DEPTH;
			else if (pick < 70)
				len = $urandom_range(1, 5);
			else
				len = $urandom_range(6, 20);
			// The first pass writes the whole table, so no later read finds an unwritten entry.
			for (int i = 0; i < len; i++) begin
				r = noise();
				r.kind = REQ_LOAD;
				r.addr = ADDR_W'(i);
				r.hold = (phase == 0) ? '0 : step_hold();
				issue(r, 1'b0, 1'b0, NO_PIC);
				n_random++;
			end
			if (len < TABLE_DEPTH) begin
				r = noise();
				r.kind = REQ_LOAD;
				r.addr = ADDR_W'(len);
				r.hold = {1'b1, 24'($urandom)};
				issue(r, 1'b0, 1'b0, NO_PIC);
				n_random++;
			end
			steady = (phase == 0) || ($urandom_range(0, 2) == 0);
			burst = $urandom_range(100, 160);
			for (int k = 0; k < burst; k++) begin
				r = noise();
				pick = $urandom_range(0, 99);
				if (!player_on && pick < 40)
					r.kind = REQ_START;
				else if (steady || pick < 88)
					r.kind = REQ_TICK;
				else if (pick < 94) begin
					r.kind = REQ_LOAD;
					r.hold = any_hold();
				end else if (pick < 97)
					r.kind = REQ_START;
				else
					r.kind = REQ_STOP;
				if (r.kind != REQ_TICK || player_on)
					n_random++;
				issue(r, 1'b0, 1'b0, NO_PIC);
			end
			phase++;
		end

		settle();
		$display("covered %0d ticks, %0d loads, %0d starts and %0d stops", n_ticks, n_loads,
			n_starts, n_stops);
		$display("under %0d play settings; %0d pictures checked", n_settings, checked);
		if (mismatches == 0)
			$display("led_point_sequence_player_core_test: done, clean");
		else
			$display("led_point_sequence_player_core_test: done, errors");
		$finish;
	end

endmodule
